@@ rtl/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
`default_nettype none
package mexp_pkg;

  localparam int DATA_W = 16;

  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              error;
  } out_t;

endpackage
`default_nettype wire

@@ rtl/modular_exponentiation.sv @@
// Right-to-left binary modular exponentiation with a bit-serial modular multiplier.
// Sequence: a zero modulus or zero exponent goes straight to the finish state; otherwise
//   the base is reduced, then each scanned exponent bit takes a multiply if set and a
//   square before the next bit (none after the top set bit), and the finish state loads
//   the result into the output register once that register is free.
// Transactions: one at a time; the next is accepted once the result is loaded and the
//   block is back in idle. The interleaved multiplier takes one multiplier bit per cycle.
//   A finished result waits in the output register while the next transaction is
//   accepted.
// Reset: rst_n (synchronous, active low) returns to idle and clears out_valid.
`default_nettype none
module modular_exponentiation #(
  parameter int WIDTH = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  mexp_pkg::in_t    in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output mexp_pkg::out_t   out_data
);
  import mexp_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [DATA_W-1:0] EXP_MASK =
    (WIDTH >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_ACC,
    ST_SQR,
    ST_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] m_r, m_nxt;
  logic [DATA_W-1:0] e_r, e_nxt;
  logic [DATA_W-1:0] sq_r, sq_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] x_r, x_nxt;
  logic [DATA_W-1:0] y_r, y_nxt;
  logic [DATA_W-1:0] r_r, r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic [DATA_W+1:0] t_add, t_sub1, t_red;
  logic [DATA_W+1:0] m_ext;
  logic [DATA_W-1:0] e_in;
  logic              mul_last;
  logic              out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign e_in      = in_data.exponent & EXP_MASK;
  assign mul_last  = (cnt_r == CNT_W'(DATA_W - 1));

  // Interleaved multiply step: r = 2r + (y bit ? x : 0), below 3m, reduced twice to below m
  always_comb begin
    m_ext  = {2'b00, m_r};
    t_add  = {1'b0, r_r, 1'b0} + (y_r[DATA_W-1] ? {2'b00, x_r} : '0);
    t_sub1 = (t_add >= m_ext) ? (t_add - m_ext) : t_add;
    t_red  = (t_sub1 >= m_ext) ? (t_sub1 - m_ext) : t_sub1;
  end

  // Sequence reduce, conditional multiply and square per exponent bit, then load the output register
  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    sq_nxt        = sq_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // drop the delivered transaction
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          m_nxt   = in_data.modulus;
          e_nxt   = e_in;
          acc_nxt = DATA_W'(1);
          r_nxt   = '0;
          cnt_nxt = '0;
          if (in_data.modulus == '0) begin
            res_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else if (e_in == '0) begin
            res_nxt   = DATA_W'(1);
            err_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            // reduce the base: 1 * base mod m
            err_nxt   = 1'b0;
            x_nxt     = DATA_W'(1);
            y_nxt     = in_data.base;
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED, ST_SQR: begin
        r_nxt   = t_red[DATA_W-1:0];
        y_nxt   = {y_r[DATA_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (mul_last) begin
          sq_nxt  = t_red[DATA_W-1:0];
          r_nxt   = '0;
          cnt_nxt = '0;
          x_nxt   = t_red[DATA_W-1:0];
          if (e_r[0]) begin
            y_nxt     = acc_r;
            state_nxt = ST_ACC;
          end else begin
            e_nxt     = e_r >> 1;
            y_nxt     = t_red[DATA_W-1:0];
            state_nxt = ST_SQR;
          end
        end
      end
      ST_ACC: begin
        r_nxt   = t_red[DATA_W-1:0];
        y_nxt   = {y_r[DATA_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (mul_last) begin
          acc_nxt = t_red[DATA_W-1:0];
          e_nxt   = e_r >> 1;
          r_nxt   = '0;
          cnt_nxt = '0;
          x_nxt   = sq_r;
          y_nxt   = sq_r;
          if ((e_r >> 1) == '0) begin
            res_nxt   = t_red[DATA_W-1:0];
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SQR;
          end
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.result  = res_r;
          out_data_nxt.error   = err_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, datapath and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r        <= m_nxt;
    e_r        <= e_nxt;
    sq_r       <= sq_nxt;
    acc_r      <= acc_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    r_r        <= r_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire
